@@ sv/spg_pkg.sv @@
// spg_pkg: shared constants, item types and small tables of the sample pattern generator.
// Used by every module of the block; no dependencies.
`default_nettype none

package spg_pkg;

   // sizing of the index and of the fixed-point fractions
   localparam int INDEX_BITS    = 16;
   localparam int FRACTION_BITS = 32;
   localparam int COORD_BITS    = 32;
   localparam int CSR_BITS      = 5;
   localparam int N_BITS        = INDEX_BITS + 1;
   localparam int FRAC_CUT      = COORD_BITS - FRACTION_BITS;

   function automatic int base3_digits(longint value);
      longint t;
      int     cnt;
      t   = value;
      cnt = 0;
      while (t != 0) begin
         t   = t / 3;
         cnt = cnt + 1;
      end
      return cnt;
   endfunction

   function automatic longint pow3(int k);
      longint acc;
      acc = 1;
      for (int i = 0; i < k; i++) begin
         acc = acc * 3;
      end
      return acc;
   endfunction

   // base-3 digit extraction, two digits per stage
   localparam int MAX_DIGITS   = base3_digits(longint'(1) << INDEX_BITS);
   localparam int DEN_BITS     = $clog2(pow3(MAX_DIGITS) + 1);
   localparam int DIGIT_STAGES = (MAX_DIGITS + 1) / 2;

   // divide by 9 as multiply by reciprocal; 2^shift = 1 mod 9 so the error term is 8
   localparam int     DIV9_SHIFT = 6 * ((INDEX_BITS + 4 + 5) / 6);
   localparam longint DIV9_MUL   = ((longint'(1) << DIV9_SHIFT) + 8) / 9;
   localparam int     PROD_BITS  = N_BITS + DIV9_SHIFT;

   // restoring long division of the base-3 fraction
   localparam int STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES      = (FRACTION_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int DIV_STEPS       = DIV_STAGES * STEPS_PER_STAGE;
   localparam int DIV_PAD         = DIV_STEPS - FRACTION_BITS;

   localparam logic [CSR_BITS-1:0]   COUNT_LOG2_RESET = CSR_BITS'(10);
   localparam logic [COORD_BITS-1:0] ONE_MAX =
      COORD_BITS'((longint'(1) << FRACTION_BITS) - longint'(1));

   typedef enum logic [1:0] {
      CMD_HALTON     = 2'd0,
      CMD_HAMMERSLEY = 2'd1,
      CMD_SOBOL      = 2'd2,
      CMD_BAYER      = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [INDEX_BITS-1:0]   index;
   } req_item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]   coord_x;
      logic [COORD_BITS-1:0]   coord_y;
      logic                    saturated;
   } rsp_item_type;

   // finished result plus the flag that the halton y is still to come
   typedef struct packed {
      logic                    halton;
      rsp_item_type            rsp;
   } side_type;

   typedef struct packed {
      side_type                side;
      logic [N_BITS-1:0]       num;
      logic [DEN_BITS-1:0]     digits;
      logic [DEN_BITS-1:0]     den;
   } digit_item_type;

   typedef struct packed {
      side_type                side;
      logic [DEN_BITS-1:0]     rem;
      logic [DEN_BITS-1:0]     den;
      logic [DIV_STEPS-1:0]    quot;
   } div_item_type;

   function automatic logic [COORD_BITS-1:0] bit_reverse32(logic [COORD_BITS-1:0] v);
      logic [COORD_BITS-1:0] r;
      for (int i = 0; i < COORD_BITS; i++) begin
         r[i] = v[COORD_BITS-1-i];
      end
      return r;
   endfunction

   function automatic logic [3:0] dither_4x4(logic [3:0] pos);
      logic [3:0] d;
      case (pos)
         4'd0:    d = 4'd0;
         4'd1:    d = 4'd8;
         4'd2:    d = 4'd2;
         4'd3:    d = 4'd10;
         4'd4:    d = 4'd12;
         4'd5:    d = 4'd4;
         4'd6:    d = 4'd14;
         4'd7:    d = 4'd6;
         4'd8:    d = 4'd3;
         4'd9:    d = 4'd11;
         4'd10:   d = 4'd1;
         4'd11:   d = 4'd9;
         4'd12:   d = 4'd15;
         4'd13:   d = 4'd7;
         4'd14:   d = 4'd13;
         default: d = 4'd5;
      endcase
      return d;
   endfunction

   // r = d0 + 3*d1 (low digit first) becomes 3*d0 + d1 for the reversed number
   function automatic logic [3:0] pair_swap(logic [3:0] r);
      logic [3:0] s;
      case (r)
         4'd0:    s = 4'd0;
         4'd1:    s = 4'd3;
         4'd2:    s = 4'd6;
         4'd3:    s = 4'd1;
         4'd4:    s = 4'd4;
         4'd5:    s = 4'd7;
         4'd6:    s = 4'd2;
         4'd7:    s = 4'd5;
         4'd8:    s = 4'd8;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

@@ sv/spg_front.sv @@
// spg_front: input stage; computes the bit-reversal, hammersley and bayer results.
// Depends on spg_pkg.
`default_nettype none

module spg_front
   import spg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire req_item_type        in_item,
   input  wire logic [CSR_BITS-1:0] count_log2,
   output logic                     out_valid,
   output digit_item_type           out_item
);

   logic                                  valid_ff;
   digit_item_type                        item_ff;
   digit_item_type                        item_in;
   logic [N_BITS-1:0]                     num;
   logic [COORD_BITS-1:0]                 rev_num;
   logic [COORD_BITS-1:0]                 rev_index;
   logic [INDEX_BITS+FRACTION_BITS-1:0]   ham_wide;
   logic                                  ham_sat;

   always_comb begin
      num       = N_BITS'(in_item.index) + N_BITS'(1);
      rev_num   = bit_reverse32(COORD_BITS'(num));
      rev_index = bit_reverse32(COORD_BITS'(in_item.index));
      // index / 2^count_log2 with FRACTION_BITS fraction bits
      ham_wide  = {in_item.index, {FRACTION_BITS{1'b0}}} >> count_log2;
      ham_sat   = |ham_wide[INDEX_BITS+FRACTION_BITS-1:FRACTION_BITS];

      item_in.num                = num;
      item_in.digits             = '0;
      item_in.den                = DEN_BITS'(1);
      item_in.side.halton        = (in_item.cmd == CMD_HALTON);
      item_in.side.rsp.saturated = 1'b0;
      case (in_item.cmd)
         CMD_HALTON: begin
            item_in.side.rsp.coord_x = rev_num >> FRAC_CUT;
            item_in.side.rsp.coord_y = '0;
         end
         CMD_HAMMERSLEY: begin
            item_in.side.rsp.coord_x   = ham_sat ? ONE_MAX
                                                 : COORD_BITS'(ham_wide[FRACTION_BITS-1:0]);
            item_in.side.rsp.coord_y   = rev_index >> FRAC_CUT;
            item_in.side.rsp.saturated = ham_sat;
         end
         CMD_SOBOL: begin
            item_in.side.rsp.coord_x = rev_num >> FRAC_CUT;
            item_in.side.rsp.coord_y = (rev_num >> 1) >> FRAC_CUT;
         end
         default: begin
            item_in.side.rsp.coord_x = COORD_BITS'({dither_4x4(in_item.index[3:0]),
                                                     {(FRACTION_BITS-4){1'b0}}});
            item_in.side.rsp.coord_y = COORD_BITS'({dither_4x4(in_item.index[3:0]),
                                                     {(FRACTION_BITS-4){1'b0}}});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

@@ sv/spg_digit_stage.sv @@
// spg_digit_stage: one pipeline stage that peels up to two base-3 digits off the index.
// Depends on spg_pkg.
`default_nettype none

module spg_digit_stage
   import spg_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  wire digit_item_type  in_item,
   output logic                 out_valid,
   output digit_item_type       out_item
);

   localparam int EXT_BITS = N_BITS + 4;

   logic                   valid_ff;
   digit_item_type         item_ff;
   digit_item_type         item_in;
   logic [PROD_BITS-1:0]   prod;
   logic [N_BITS-1:0]      quo;
   logic [EXT_BITS-1:0]    diff;
   logic [3:0]             rem;

   always_comb begin
      prod = PROD_BITS'(in_item.num) * PROD_BITS'(DIV9_MUL);
      quo  = prod[DIV9_SHIFT +: N_BITS];
      diff = EXT_BITS'(in_item.num) - (EXT_BITS'(quo) << 3) - EXT_BITS'(quo);
      rem  = diff[3:0];

      item_in = in_item;
      if (in_item.num != '0) begin
         if ((quo == '0) && (rem < 4'd3)) begin
            // a single digit left
            item_in.digits = (in_item.digits << 1) + in_item.digits + DEN_BITS'(rem);
            item_in.den    = (in_item.den << 1) + in_item.den;
            item_in.num    = '0;
         end else begin
            item_in.digits = (in_item.digits << 3) + in_item.digits
                             + DEN_BITS'(pair_swap(rem));
            item_in.den    = (in_item.den << 3) + in_item.den;
            item_in.num    = quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   a_digits_below_den: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (item_ff.digits < item_ff.den))
      else $error("reversed digits not below the power of three");

endmodule

`default_nettype wire

@@ sv/spg_div_stage.sv @@
// spg_div_stage: one pipeline stage of restoring division, four quotient bits per stage.
// Depends on spg_pkg.
`default_nettype none

module spg_div_stage
   import spg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          in_valid,
   input  wire div_item_type  in_item,
   output logic               out_valid,
   output div_item_type       out_item
);

   logic                   valid_ff;
   div_item_type           item_ff;
   div_item_type           item_in;
   logic [DEN_BITS-1:0]    rem_v;
   logic [DEN_BITS:0]      trial;
   logic [DIV_STEPS-1:0]   quot_v;

   always_comb begin
      rem_v  = in_item.rem;
      quot_v = in_item.quot;
      trial  = '0;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
         trial = {rem_v, 1'b0};
         if (trial >= {1'b0, in_item.den}) begin
            rem_v  = DEN_BITS'(trial - {1'b0, in_item.den});
            quot_v = {quot_v[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_v  = trial[DEN_BITS-1:0];
            quot_v = {quot_v[DIV_STEPS-2:0], 1'b0};
         end
      end
      item_in      = in_item;
      item_in.rem  = rem_v;
      item_in.quot = quot_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (item_ff.rem < item_ff.den))
      else $error("division remainder not below divisor");

endmodule

`default_nettype wire

@@ sv/sample_pattern_generator.sv @@
// sample_pattern_generator: top level; config register, stage chain and output register.
// Depends on spg_pkg, spg_front, spg_digit_stage and spg_div_stage.
//
// Usage:
//   req_valid/req_stall/req_data carries one item per accepted edge: a pattern
//   code (halton, hammersley, sobol, bayer) and a 16-bit sample index.
//   rsp_valid/rsp_stall/rsp_data returns one item per request, in order:
//   coord_x, coord_y as unsigned fractions with 32 fraction bits and the
//   hammersley saturation flag.
//   csr_write/csr_wdata writes count_log2 (reset value 10); write it only
//   while no item is in flight.
// Pipeline:
//   The item walks 16 register stages: one input stage, six stages that take
//   up to two base-3 digits each, eight stages of four-bit restoring division
//   for the halton y, and the output register.
//   Throughput is one item per cycle while rsp_stall does not hold the chain;
//   every pattern walks the same stages.
// Reset clears all valid bits and sets count_log2 to 10.
// While rsp_valid is high and rsp_stall is high the whole chain holds and
// req_stall is raised in the same cycle; nothing is dropped or repeated.
`default_nettype none

module sample_pattern_generator
   import spg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_item_type        req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_item_type             rsp_data,
   input  wire logic                csr_write,
   input  wire logic [CSR_BITS-1:0] csr_wdata
);

   logic [CSR_BITS-1:0]  count_log2_ff;
   logic                 advance;
   logic                 rsp_valid_ff;
   rsp_item_type         rsp_data_ff;
   rsp_item_type         rsp_data_in;
   logic                 dig_valid [0:DIGIT_STAGES];
   digit_item_type       dig_item  [0:DIGIT_STAGES];
   logic                 div_valid [0:DIV_STAGES];
   div_item_type         div_item  [0:DIV_STAGES];

   // the chain moves unless a finished item is held by the receiver
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_log2_ff <= COUNT_LOG2_RESET;
      end else if (csr_write) begin
         count_log2_ff <= csr_wdata;
      end
   end

   spg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .in_item    (req_data),
      .count_log2 (count_log2_ff),
      .out_valid  (dig_valid[0]),
      .out_item   (dig_item[0])
   );

   for (genvar g = 0; g < DIGIT_STAGES; g++) begin : g_digit
      spg_digit_stage u_digit (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dig_valid[g]),
         .in_item   (dig_item[g]),
         .out_valid (dig_valid[g+1]),
         .out_item  (dig_item[g+1])
      );
   end

   always_comb begin
      div_valid[0]     = dig_valid[DIGIT_STAGES];
      div_item[0].side = dig_item[DIGIT_STAGES].side;
      div_item[0].rem  = dig_item[DIGIT_STAGES].digits;
      div_item[0].den  = dig_item[DIGIT_STAGES].den;
      div_item[0].quot = '0;
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      spg_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (div_valid[g]),
         .in_item   (div_item[g]),
         .out_valid (div_valid[g+1]),
         .out_item  (div_item[g+1])
      );
   end

   always_comb begin
      rsp_data_in = div_item[DIV_STAGES].side.rsp;
      if (div_item[DIV_STAGES].side.halton) begin
         rsp_data_in.coord_y = COORD_BITS'(div_item[DIV_STAGES].quot >> DIV_PAD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid[DIV_STAGES];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> dig_valid[0])
      else $error("accepted item did not enter the first stage");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(dig_valid[1]) && $stable(div_valid[1])))
      else $error("pipeline moved while the output was held");

   a_sat_clamps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.saturated) |-> (rsp_data_ff.coord_x == ONE_MAX))
      else $error("saturated item without clamped x");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking testbench for sample_pattern_generator (halton, hammersley,
// sobol and bayer sample points, count_log2 register). Depends on spg_pkg and the block.
`timescale 1ns / 1ps

module tb_top
   import spg_pkg::*;
;

   localparam int CLOCK_PERIOD = 8;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int FLUSH_CYCLES = 40;
   localparam int LONG_HOLD    = 300;
   localparam int PHASE_ITEMS  = 190;
   localparam int N_PHASES     = 9;
   localparam int N_DIRECTED   = 22;
   localparam int PRINT_CAP    = 100;

   localparam logic [3:0] BAYER_LEVEL [16] =
      '{4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
        4'd3, 4'd11, 4'd1, 4'd9, 4'd15, 4'd7, 4'd13, 4'd5};

   // count_log2 settings, one per random phase; the last one is drawn at run time
   localparam logic [CSR_BITS-1:0] COUNT_PLAN [N_PHASES] =
      '{5'd0, 5'd31, 5'd16, 5'd10, 5'd1, 5'd22, 5'd17, 5'd15, 5'd10};

   typedef struct packed {
      req_item_type  item;
      logic          typed;
      rsp_item_type  want;
   } dir_row_type;

   // rows with typed set carry their own expected point; the rest use the predictor
   localparam dir_row_type DIR_ROWS [N_DIRECTED] = '{
      '{'{CMD_HALTON,     16'h0000}, 1'b1, '{32'h8000_0000, 32'h5555_5555, 1'b0}},
      '{'{CMD_HALTON,     16'h0001}, 1'b1, '{32'h4000_0000, 32'hAAAA_AAAA, 1'b0}},
      '{'{CMD_HALTON,     16'h0002}, 1'b0, '0},
      '{'{CMD_HALTON,     16'hFFFF}, 1'b0, '0},
      '{'{CMD_HALTON,     16'h5555}, 1'b0, '0},
      '{'{CMD_HALTON,     16'hAAAA}, 1'b0, '0},
      '{'{CMD_HAMMERSLEY, 16'h0000}, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
      '{'{CMD_HAMMERSLEY, 16'h0001}, 1'b1, '{32'h0040_0000, 32'h8000_0000, 1'b0}},
      '{'{CMD_HAMMERSLEY, 16'h03FF}, 1'b1, '{32'hFFC0_0000, 32'hFFC0_0000, 1'b0}},
      '{'{CMD_HAMMERSLEY, 16'h0400}, 1'b1, '{32'hFFFF_FFFF, 32'h0020_0000, 1'b1}},
      '{'{CMD_HAMMERSLEY, 16'hFFFF}, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_0000, 1'b1}},
      '{'{CMD_HAMMERSLEY, 16'h0155}, 1'b0, '0},
      '{'{CMD_HAMMERSLEY, 16'h5555}, 1'b0, '0},
      '{'{CMD_SOBOL,      16'h0000}, 1'b1, '{32'h8000_0000, 32'h4000_0000, 1'b0}},
      '{'{CMD_SOBOL,      16'hFFFF}, 1'b1, '{32'h0000_8000, 32'h0000_4000, 1'b0}},
      '{'{CMD_SOBOL,      16'hAAAA}, 1'b0, '0},
      '{'{CMD_SOBOL,      16'h5554}, 1'b0, '0},
      '{'{CMD_BAYER,      16'h0000}, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
      '{'{CMD_BAYER,      16'h000F}, 1'b1, '{32'h5000_0000, 32'h5000_0000, 1'b0}},
      '{'{CMD_BAYER,      16'h0006}, 1'b1, '{32'hE000_0000, 32'hE000_0000, 1'b0}},
      '{'{CMD_BAYER,      16'hFFFF}, 1'b1, '{32'h5000_0000, 32'h5000_0000, 1'b0}},
      '{'{CMD_BAYER,      16'hABCD}, 1'b0, '0}
   };

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_item_type        req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_item_type        rsp_data;
   logic                csr_write = 1'b0;
   logic [CSR_BITS-1:0] csr_wdata = '0;

   rsp_item_type        pending_points[$];
   logic [CSR_BITS-1:0] count_shadow = COUNT_LOG2_RESET;
   int                  error_count  = 0;
   bit                  calm         = 1'b0;
   bit                  hold_off_req = 1'b0;

   sample_pattern_generator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever begin
         #(CLOCK_PERIOD / 2) clock = ~clock;
      end
   end

   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("tb_top: errors");
      $finish;
   end

   function automatic logic [31:0] flip_bits(logic [31:0] v);
      return {<<{v}};
   endfunction

   // exact base-3 radical inverse of n, truncated to 32 fraction bits
   function automatic logic [31:0] base3_fraction(int unsigned n);
      logic [63:0] digits;
      logic [63:0] den;
      digits = '0;
      den    = 64'd1;
      while (n != 0) begin
         digits = digits * 3 + 64'(n % 3);
         n      = n / 3;
         den    = den * 3;
      end
      return 32'((digits << 32) / den);
   endfunction

   function automatic rsp_item_type sample_point(req_item_type it, logic [CSR_BITS-1:0] log2n);
      rsp_item_type r;
      logic [31:0]  next_index;
      logic [31:0]  rv;
      logic [63:0]  wide;
      r          = '0;
      next_index = 32'(it.index) + 32'd1;
      case (it.cmd)
         CMD_HALTON: begin
            r.coord_x = flip_bits(next_index);
            r.coord_y = base3_fraction(next_index);
         end
         CMD_HAMMERSLEY: begin
            wide = 64'(it.index) << (32 - int'(log2n));
            if (wide > 64'hFFFF_FFFF) begin
               r.coord_x   = ONE_MAX;
               r.saturated = 1'b1;
            end else begin
               r.coord_x = wide[31:0];
            end
            r.coord_y = flip_bits(32'(it.index));
         end
         CMD_SOBOL: begin
            rv        = flip_bits(next_index);
            r.coord_x = rv;
            r.coord_y = rv >> 1;
         end
         default: begin
            r.coord_x = {BAYER_LEVEL[it.index[3:0]], 28'd0};
            r.coord_y = r.coord_x;
         end
      endcase
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   // index biased toward the hammersley saturation edge and the field extremes
   function automatic logic [INDEX_BITS-1:0] pick_index(logic [CSR_BITS-1:0] log2n);
      logic [16:0] edge_val;
      int          lim;
      lim      = (log2n > 16) ? 16 : int'(log2n);
      edge_val = 17'd1 << lim;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return edge_val[15:0];
         3:       return 16'(edge_val - 17'd1);
         4:       return 16'd1 << $urandom_range(0, 15);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (error_count < PRINT_CAP) begin
         $display("tb_top: %0t %s got %h want %h", $realtime, what, got, want);
      end
      error_count++;
   endtask

   // offer one item and hold it until the block takes it
   task automatic send_item(req_item_type it, bit typed, rsp_item_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_points.insert(pending_points.size(),
                            typed ? want : sample_point(it, count_shadow));
   endtask

   task automatic drain_points();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) begin
         @(posedge clock);
      end
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic write_count_log2(logic [CSR_BITS-1:0] v);
      drain_points();
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      count_shadow = v;
   endtask

   // result side back-pressure
   initial begin
      int run;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            run = pick_gap();
            if (run > 0) begin
               rsp_stall <= 1'b1;
               repeat (run) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat (calm ? 4 : $urandom_range(1, 5)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            flag_mismatch("item with none expected, coord_x", rsp_data.coord_x, 'x);
         end else begin
            want = pending_points.pop_front();
            if (rsp_data.coord_x !== want.coord_x) begin
               flag_mismatch("coord_x", rsp_data.coord_x, want.coord_x);
            end
            if (rsp_data.coord_y !== want.coord_y) begin
               flag_mismatch("coord_y", rsp_data.coord_y, want.coord_y);
            end
            if (rsp_data.saturated !== want.saturated) begin
               flag_mismatch("saturated", 32'(rsp_data.saturated), 32'(want.saturated));
            end
         end
      end
   end

   initial begin
      req_item_type        it;
      logic [CSR_BITS-1:0] setting;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows run with count_log2 at its reset value
      for (int r = 0; r < N_DIRECTED; r++) begin
         send_item(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         setting = (p == N_PHASES - 1) ? CSR_BITS'($urandom_range(0, 31)) : COUNT_PLAN[p];
         write_count_log2(setting);
         calm = (p == 2);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 60) begin
               hold_off_req = 1'b1;
            end
            if (p == 3 && i == 100) begin
               drain_points();
            end
            it.cmd   = cmd_type'($urandom_range(0, 3));
            it.index = pick_index(count_shadow);
            send_item(it, 1'b0, '0);
         end
      end

      calm = 1'b0;
      drain_points();
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
